// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file gmc_checker.sv.
// Needs clk_i, and for GMC_ASSERT also rst_ni, in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, muted while reset is asserted.
`define GMC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked property checked through reset as well.
`define GMC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== design/gmc_pkg.sv =====
// Shared types and constants of the gate motor controller.
// No dependencies; used by every other design file but assert_macros.svh.
`timescale 1ns / 1ps

package gmc_pkg;

  localparam int unsigned DUTY_BITS_DEF  = 10;
  localparam int unsigned COUNT_BITS_DEF = 16;

  localparam int unsigned OPEN_DUTY_RESET  = 632;
  localparam int unsigned CLOSE_DUTY_RESET = 250;
  localparam int unsigned DELAY_RESET      = 39062;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned DELAY_W     = 16;

  typedef enum logic [2:0] {
    PH_POWERUP = 3'd0,
    PH_IDLE    = 3'd1,
    PH_OPENING = 3'd2,
    PH_CLOSING = 3'd3,
    PH_WAIT    = 3'd4,
    PH_STOPPED = 3'd5
  } phase_e;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_OPEN_DUTY   = 2'd0,
    REG_CLOSE_DUTY  = 2'd1,
    REG_CLOSE_DELAY = 2'd2
  } cfg_reg_e;

  // Motor and lamp controls of one tick.
  typedef struct packed {
    logic open_en;
    logic close_en;
    logic fault;
  } ctl_t;

endpackage

// ===== design/gmc_step.sv =====
// Next-state logic of the gate phase machine for one sampled tick.
// Depends on gmc_pkg.
`timescale 1ns / 1ps

module gmc_step #(
  parameter int unsigned COUNT_BITS = gmc_pkg::COUNT_BITS_DEF
) (
  input  gmc_pkg::phase_e                phase_i,
  input  gmc_pkg::phase_e                resume_i,
  input  logic [COUNT_BITS-1:0]          count_i,
  input  logic                           stop_prev_i,
  input  logic                           limit_open_i,
  input  logic                           limit_closed_i,
  input  logic                           stop_button_i,
  input  logic                           open_button_i,
  input  logic                           close_button_i,
  input  logic [gmc_pkg::DELAY_W-1:0]    delay_i,
  output gmc_pkg::phase_e                phase_o,
  output gmc_pkg::phase_e                resume_o,
  output logic [COUNT_BITS-1:0]          count_o,
  output gmc_pkg::ctl_t                  ctl_o
);

  localparam int unsigned CMP_W =
    (COUNT_BITS > gmc_pkg::DELAY_W) ? COUNT_BITS : gmc_pkg::DELAY_W;

  logic lo, lc, ob, cb, stop;
  logic fault, stop_edge;
  logic idle_go_open, idle_go_close, idle_go_wait;
  logic start_close_ok;
  logic [COUNT_BITS-1:0] count_inc;
  logic delay_done;
  gmc_pkg::phase_e eff_phase;
  gmc_pkg::phase_e idle_phase;

  assign lo   = limit_open_i;
  assign lc   = limit_closed_i;
  assign ob   = open_button_i;
  assign cb   = close_button_i;
  assign stop = stop_button_i;

  assign fault     = (lo && lc) || (ob && cb);
  assign stop_edge = stop && !stop_prev_i;

  // Idle: a fault, a held stop or a closed gate starts nothing.
  assign idle_go_close = !fault && !stop && !lc && cb && !ob;
  assign idle_go_open  = !fault && !stop && !lc && !lo && ob && !cb;
  assign idle_go_wait  = !fault && !stop && !lc && lo && !cb;

  always_comb begin
    if (idle_go_close) begin
      idle_phase = gmc_pkg::PH_CLOSING;
    end else if (idle_go_open) begin
      idle_phase = gmc_pkg::PH_OPENING;
    end else if (idle_go_wait) begin
      idle_phase = gmc_pkg::PH_WAIT;
    end else begin
      idle_phase = gmc_pkg::PH_IDLE;
    end
  end

  assign start_close_ok = !lc && !ob;
  assign count_inc  = (count_i == '1) ? count_i : count_i + 1'b1;
  assign delay_done = CMP_W'(count_inc) >= CMP_W'(delay_i);

  always_comb begin
    phase_o        = phase_i;
    resume_o       = resume_i;
    count_o        = count_i;
    ctl_o.open_en  = 1'b0;
    ctl_o.close_en = 1'b0;
    ctl_o.fault    = fault;
    eff_phase      = phase_i;

    if (stop_edge && phase_i != gmc_pkg::PH_STOPPED) begin
      if (phase_i == gmc_pkg::PH_OPENING || phase_i == gmc_pkg::PH_CLOSING ||
          phase_i == gmc_pkg::PH_WAIT) begin
        resume_o = phase_i;
      end else begin
        resume_o = gmc_pkg::PH_IDLE;
      end
      phase_o = gmc_pkg::PH_STOPPED;
    end else begin
      // A button releases a stopped gate into the interrupted phase.
      if (phase_i == gmc_pkg::PH_STOPPED && (ob || cb)) begin
        eff_phase = resume_i;
      end
      unique case (eff_phase)
        gmc_pkg::PH_STOPPED: begin
          phase_o = gmc_pkg::PH_STOPPED;
        end
        gmc_pkg::PH_POWERUP: begin
          if (!lo && !lc && !ob && !cb) begin
            phase_o       = gmc_pkg::PH_OPENING;
            ctl_o.open_en = 1'b1;
          end else begin
            phase_o        = idle_phase;
            ctl_o.open_en  = idle_go_open;
            ctl_o.close_en = idle_go_close;
            if (idle_go_wait) begin
              count_o = '0;
            end
          end
        end
        gmc_pkg::PH_OPENING: begin
          if (lo || cb) begin
            phase_o = gmc_pkg::PH_IDLE;
          end else begin
            phase_o       = gmc_pkg::PH_OPENING;
            ctl_o.open_en = 1'b1;
          end
        end
        gmc_pkg::PH_CLOSING: begin
          if (lc || ob) begin
            phase_o = gmc_pkg::PH_IDLE;
          end else begin
            phase_o        = gmc_pkg::PH_CLOSING;
            ctl_o.close_en = 1'b1;
          end
        end
        gmc_pkg::PH_WAIT: begin
          if (!cb) begin
            count_o = count_inc;
          end
          if (cb || delay_done) begin
            phase_o        = start_close_ok ? gmc_pkg::PH_CLOSING : gmc_pkg::PH_IDLE;
            ctl_o.close_en = start_close_ok;
          end else begin
            phase_o = gmc_pkg::PH_WAIT;
          end
        end
        default: begin
          phase_o        = idle_phase;
          ctl_o.open_en  = idle_go_open;
          ctl_o.close_en = idle_go_close;
          if (idle_go_wait) begin
            count_o = '0;
          end
        end
      endcase
    end
  end

endmodule

// ===== design/gate_motor_controller.sv =====
// Top level of the gate motor controller: input stage, phase state, result stage.
// Depends on gmc_pkg and gmc_step.
`timescale 1ns / 1ps

// Usage
//   Input channel: one transfer per sampled tick of the two limit switches and
//   the stop, open and close buttons (in_valid_i / in_stall_o).
//   Output channel: one result per tick with the close and open duties, the
//   fault lamp and the phase after that tick (out_valid_o / out_stall_i).
//   Config channel: cfg_valid_i / cfg_ready_o with a register index and data;
//   0 open duty, 1 close duty, 2 auto-close delay. Always ready; write it only
//   while no tick is in flight.
//   Path: a tick passes the input register, the phase logic, then the result register.
//   Throughput: one tick per cycle while out_stall_i is low, set by the single
//   registered pass through the phase logic between input and result registers.
//   Stall: a valid result holds while out_stall_i is high, and the input
//   register still takes one more tick; in_stall_o rises only when both hold.
//   Reset: power-up phase, resume as idle, counter and stop history cleared,
//   registers back to their default duties and delay; nothing in flight.
module gate_motor_controller #(
  parameter int unsigned DUTY_BITS  = gmc_pkg::DUTY_BITS_DEF,
  parameter int unsigned COUNT_BITS = gmc_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            limit_open_i,
  input  logic                            limit_closed_i,
  input  logic                            stop_button_i,
  input  logic                            open_button_i,
  input  logic                            close_button_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [DUTY_BITS-1:0]            close_drive_o,
  output logic [DUTY_BITS-1:0]            open_drive_o,
  output logic                            fault_lamp_o,
  output logic [2:0]                      phase_now_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [gmc_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [gmc_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  // Configuration registers
  logic [DUTY_BITS-1:0]        open_duty_q, close_duty_q;
  logic [gmc_pkg::DELAY_W-1:0] delay_q;

  // Input stage
  logic in_valid_q, in_valid_d;
  logic lo_q, lc_q, stop_q, ob_q, cb_q;
  logic in_accept;

  // Phase state
  gmc_pkg::phase_e       phase_q, phase_d, resume_q, resume_d;
  logic [COUNT_BITS-1:0] wait_q, wait_d;
  logic                  stop_prev_q;
  gmc_pkg::ctl_t         ctl;

  // Result stage
  logic                  out_valid_q, out_valid_d;
  logic                  out_ready, advance;
  logic [DUTY_BITS-1:0]  close_drive_q, open_drive_q;
  logic                  fault_q;
  gmc_pkg::phase_e       phase_now_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_duty_q  <= DUTY_BITS'(gmc_pkg::OPEN_DUTY_RESET);
      close_duty_q <= DUTY_BITS'(gmc_pkg::CLOSE_DUTY_RESET);
      delay_q      <= gmc_pkg::DELAY_W'(gmc_pkg::DELAY_RESET);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (gmc_pkg::cfg_reg_e'(cfg_index_i))
        gmc_pkg::REG_OPEN_DUTY:   open_duty_q  <= cfg_wdata_i[DUTY_BITS-1:0];
        gmc_pkg::REG_CLOSE_DUTY:  close_duty_q <= cfg_wdata_i[DUTY_BITS-1:0];
        gmc_pkg::REG_CLOSE_DELAY: delay_q      <= cfg_wdata_i[gmc_pkg::DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_ready   = !out_valid_q || !out_stall_i;
  assign advance     = in_valid_q && out_ready;
  assign in_stall_o  = in_valid_q && !out_ready;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign in_valid_d  = in_accept || (in_valid_q && !out_ready);
  assign out_valid_d = advance || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      lo_q   <= limit_open_i;
      lc_q   <= limit_closed_i;
      stop_q <= stop_button_i;
      ob_q   <= open_button_i;
      cb_q   <= close_button_i;
    end
  end

  gmc_step #(
    .COUNT_BITS(COUNT_BITS)
  ) u_step (
    .phase_i       (phase_q),
    .resume_i      (resume_q),
    .count_i       (wait_q),
    .stop_prev_i   (stop_prev_q),
    .limit_open_i  (lo_q),
    .limit_closed_i(lc_q),
    .stop_button_i (stop_q),
    .open_button_i (ob_q),
    .close_button_i(cb_q),
    .delay_i       (delay_q),
    .phase_o       (phase_d),
    .resume_o      (resume_d),
    .count_o       (wait_d),
    .ctl_o         (ctl)
  );

  // Advance the phase state once per tick moved into the result stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= gmc_pkg::PH_POWERUP;
      resume_q    <= gmc_pkg::PH_IDLE;
      wait_q      <= '0;
      stop_prev_q <= 1'b0;
    end else if (advance) begin
      phase_q     <= phase_d;
      resume_q    <= resume_d;
      wait_q      <= wait_d;
      stop_prev_q <= stop_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      close_drive_q <= ctl.close_en ? close_duty_q : '0;
      open_drive_q  <= ctl.open_en ? open_duty_q : '0;
      fault_q       <= ctl.fault;
      phase_now_q   <= phase_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign close_drive_o = close_drive_q;
  assign open_drive_o  = open_drive_q;
  assign fault_lamp_o  = fault_q;
  assign phase_now_o   = phase_now_q;

endmodule

// ===== design/gmc_checker.sv =====
// Port-level assertions for the gate motor controller, bound to the top level.
// Depends on gmc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gmc_checker #(
  parameter int unsigned DUTY_BITS = gmc_pkg::DUTY_BITS_DEF
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [DUTY_BITS-1:0] close_drive_o,
  input logic [DUTY_BITS-1:0] open_drive_o,
  input logic                 fault_lamp_o,
  input logic [2:0]           phase_now_o
);

  `GMC_ASSERT(a_no_dual_drive, out_valid_o |-> (close_drive_o == '0 || open_drive_o == '0), "both motor outputs driven")
  `GMC_ASSERT(a_open_only_opening, (out_valid_o && phase_now_o != gmc_pkg::PH_OPENING) |-> open_drive_o == '0, "open drive outside opening phase")
  `GMC_ASSERT(a_close_only_closing, (out_valid_o && phase_now_o != gmc_pkg::PH_CLOSING) |-> close_drive_o == '0, "close drive outside closing phase")
  `GMC_ASSERT(a_out_hold, (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(close_drive_o) && $stable(open_drive_o) && $stable(fault_lamp_o) && $stable(phase_now_o)), "stalled result changed")
  `GMC_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !out_valid_o, "result valid during reset")

endmodule

bind gate_motor_controller gmc_checker #(
  .DUTY_BITS(DUTY_BITS)
) u_gmc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .close_drive_o(close_drive_o),
  .open_drive_o (open_drive_o),
  .fault_lamp_o (fault_lamp_o),
  .phase_now_o  (phase_now_o)
);
